// File: hw/rtl/tbps_pkg.sv
package tbps_pkg;

  // Data widths.
  localparam int CoordW = 32;
  localparam int AddrW  = 5;
  localparam int DataW  = 32;
  localparam int HalfW  = 31;
  localparam int ProdW  = 62;
  localparam int DistW  = 64;
  localparam int MagW   = 63;
  localparam int TW     = 31;
  localparam int DivSteps = 5;
  localparam int DivCycles = 6;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_SEED_A_X = 3'd0;
  localparam logic [2:0] REG_SEED_A_Y = 3'd1;
  localparam logic [2:0] REG_SEED_A_Z = 3'd2;
  localparam logic [2:0] REG_SEED_B_X = 3'd3;
  localparam logic [2:0] REG_SEED_B_Y = 3'd4;
  localparam logic [2:0] REG_SEED_B_Z = 3'd5;

  localparam logic [CoordW-1:0] SEED_B_X_RESET = 32'h0001_0000;

  // Piece kinds.
  localparam logic [1:0] KIND_A   = 2'd0;
  localparam logic [1:0] KIND_B   = 2'd1;
  localparam logic [1:0] KIND_SEG = 2'd2;

  // Point selectors used when a piece is assembled.
  localparam logic [2:0] SEL_V0   = 3'd0;
  localparam logic [2:0] SEL_V1   = 3'd1;
  localparam logic [2:0] SEL_V2   = 3'd2;
  localparam logic [2:0] SEL_C0   = 3'd3;
  localparam logic [2:0] SEL_C1   = 3'd4;
  localparam logic [2:0] SEL_ZERO = 3'd5;

  typedef struct packed {
    logic signed [CoordW-1:0] corner0_x;
    logic signed [CoordW-1:0] corner0_y;
    logic signed [CoordW-1:0] corner0_z;
    logic signed [CoordW-1:0] corner1_x;
    logic signed [CoordW-1:0] corner1_y;
    logic signed [CoordW-1:0] corner1_z;
    logic signed [CoordW-1:0] corner2_x;
    logic signed [CoordW-1:0] corner2_y;
    logic signed [CoordW-1:0] corner2_z;
  } tri_t;

  typedef struct packed {
    logic [1:0]               piece_kind;
    logic signed [CoordW-1:0] out0_x;
    logic signed [CoordW-1:0] out0_y;
    logic signed [CoordW-1:0] out0_z;
    logic signed [CoordW-1:0] out1_x;
    logic signed [CoordW-1:0] out1_y;
    logic signed [CoordW-1:0] out1_z;
    logic signed [CoordW-1:0] out2_x;
    logic signed [CoordW-1:0] out2_y;
    logic signed [CoordW-1:0] out2_z;
    logic                     final_piece;
  } piece_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } vec_t;

  typedef struct packed {
    vec_t a;
    vec_t b;
  } seeds_t;

  // Classification of one triangle against the plane.
  typedef struct packed {
    logic [1:0] ncut;
    logic [1:0] cut_edge0;
    logic [1:0] cut_edge1;
    logic [1:0] lone;
    logic       lone_pos;
    logic       e0_pos;
    logic       pass_b;
  } cls_t;

  typedef struct packed {
    vec_t [2:0]            vtx;
    logic [2:0][MagW-1:0]  mag;
    cls_t                  cls;
  } work_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] s0;
    logic [2:0] s1;
    logic [2:0] s2;
    logic       last;
  } pick_t;

  // Corner that follows corner e around the triangle.
  function automatic logic [1:0] next_corner(input logic [1:0] e);
    logic [1:0] n;
    unique case (e)
      2'd0:    n = 2'd1;
      2'd1:    n = 2'd2;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] corner_sel(input logic [1:0] e);
    return {1'b0, e};
  endfunction

  // Point selection, kind and last flag of piece ri of a triangle.
  function automatic pick_t pick_piece(input cls_t c, input logic [1:0] ri);
    pick_t      p;
    logic [1:0] lk;
    logic [1:0] qk;
    logic [2:0] ve;
    logic [2:0] vn;
    logic [2:0] vp;
    lk = c.lone_pos ? KIND_A : KIND_B;
    qk = c.lone_pos ? KIND_B : KIND_A;
    ve = corner_sel(c.cut_edge0);
    vn = corner_sel(next_corner(c.cut_edge0));
    vp = corner_sel(next_corner(next_corner(c.cut_edge0)));
    p = '{kind: KIND_SEG, s0: SEL_C0, s1: SEL_C1, s2: SEL_ZERO, last: 1'b1};
    if (c.ncut == 2'd2) begin
      if (ri == 2'd0) begin
        p.kind = lk;
        p.last = 1'b0;
        unique case (c.lone)
          2'd0:    begin p.s0 = SEL_V0; p.s1 = SEL_C0; p.s2 = SEL_C1; end
          2'd1:    begin p.s0 = SEL_V1; p.s1 = SEL_C1; p.s2 = SEL_C0; end
          default: begin p.s0 = SEL_V2; p.s1 = SEL_C1; p.s2 = SEL_C0; end
        endcase
      end else if (ri == 2'd1) begin
        p.kind = qk;
        p.last = 1'b0;
        unique case (c.lone)
          2'd0:    begin p.s0 = SEL_V1; p.s1 = SEL_V2; p.s2 = SEL_C0; end
          2'd1:    begin p.s0 = SEL_V0; p.s1 = SEL_C1; p.s2 = SEL_V2; end
          default: begin p.s0 = SEL_V0; p.s1 = SEL_V1; p.s2 = SEL_C1; end
        endcase
      end else if (ri == 2'd2) begin
        p.kind = qk;
        p.last = 1'b0;
        unique case (c.lone)
          2'd0:    begin p.s0 = SEL_V2; p.s1 = SEL_C1; p.s2 = SEL_C0; end
          2'd1:    begin p.s0 = SEL_V0; p.s1 = SEL_C0; p.s2 = SEL_C1; end
          default: begin p.s0 = SEL_V1; p.s1 = SEL_C0; p.s2 = SEL_C1; end
        endcase
      end
    end else if (c.ncut == 2'd1) begin
      if (ri == 2'd0) begin
        p.kind = KIND_A;
        p.last = 1'b0;
        p.s2   = SEL_C0;
        if (c.e0_pos) begin
          p.s0 = vp; p.s1 = ve;
        end else begin
          p.s0 = vn; p.s1 = vp;
        end
      end else if (ri == 2'd1) begin
        p.kind = KIND_B;
        p.last = 1'b0;
        p.s2   = SEL_C0;
        if (c.e0_pos) begin
          p.s0 = vn; p.s1 = vp;
        end else begin
          p.s0 = vp; p.s1 = ve;
        end
      end else begin
        p.s0 = SEL_C0;
        p.s1 = vp;
      end
    end else begin
      p.kind = c.pass_b ? KIND_B : KIND_A;
      p.s0   = SEL_V0;
      p.s1   = SEL_V1;
      p.s2   = SEL_V2;
    end
    return p;
  endfunction

endpackage

// File: hw/rtl/triangle_bisector_plane_split.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+---------------------------------------
// input    | push / full           | corners (tri_t), one triangle
// result   | empty / pop           | piece (piece_t), one to four per triangle
// config   | psel penable pwrite   | paddr, pwdata, prdata; pready tied high
//
// The front computes plane distances in a three-stage pipeline and queues the
// classified triangle; a triangle enters every cycle while the queue has room.
// The back handles one triangle at a time and emits its pieces one after another;
// each crossing point first passes through the shared normalizer (shift by
// 8 or 1 per cycle) and the divider (5 quotient bits per cycle).
// Reset (rst, synchronous) empties both queues and restores the seed registers.
// Either side may stall at any time; the queues hold work and results.
module triangle_bisector_plane_split (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  tbps_pkg::tri_t              corners,
  output logic                        empty,
  input  logic                        pop,
  output tbps_pkg::piece_t            piece,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tbps_pkg::AddrW-1:0]  paddr,
  input  logic [tbps_pkg::DataW-1:0]  pwdata,
  output logic [tbps_pkg::DataW-1:0]  prdata,
  output logic                        pready
);
  import tbps_pkg::*;

  seeds_t seeds;
  logic   wq_push, wq_full, wq_pop, wq_empty;
  work_t  wq_in, wq_head;

  tbps_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .seeds
  );

  tbps_front u_front (
    .clk, .rst, .push, .full, .corners, .seeds,
    .wq_push, .wq_data(wq_in), .wq_full
  );

  tbps_workq u_workq (
    .clk, .rst, .wr(wq_push), .wr_data(wq_in), .q_full(wq_full),
    .rd(wq_pop), .rd_data(wq_head), .q_empty(wq_empty)
  );

  tbps_back u_back (
    .clk, .rst, .wq_pop, .wq_data(wq_head), .wq_empty,
    .empty, .pop, .piece
  );

endmodule

// File: hw/rtl/tbps_regs.sv
module tbps_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tbps_pkg::AddrW-1:0]  paddr,
  input  logic [tbps_pkg::DataW-1:0]  pwdata,
  output logic [tbps_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output tbps_pkg::seeds_t            seeds
);
  import tbps_pkg::*;

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  // Seed registers, written by a completed write transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      seeds.a.x <= '0;
      seeds.a.y <= '0;
      seeds.a.z <= '0;
      seeds.b.x <= SEED_B_X_RESET;
      seeds.b.y <= '0;
      seeds.b.z <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_SEED_A_X: seeds.a.x <= pwdata;
        REG_SEED_A_Y: seeds.a.y <= pwdata;
        REG_SEED_A_Z: seeds.a.z <= pwdata;
        REG_SEED_B_X: seeds.b.x <= pwdata;
        REG_SEED_B_Y: seeds.b.y <= pwdata;
        REG_SEED_B_Z: seeds.b.z <= pwdata;
        default: ;
      endcase
    end
  end

  // Read data.
  always_comb begin
    unique case (idx)
      REG_SEED_A_X: prdata = seeds.a.x;
      REG_SEED_A_Y: prdata = seeds.a.y;
      REG_SEED_A_Z: prdata = seeds.a.z;
      REG_SEED_B_X: prdata = seeds.b.x;
      REG_SEED_B_Y: prdata = seeds.b.y;
      REG_SEED_B_Z: prdata = seeds.b.z;
      default:      prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/tbps_front.sv
module tbps_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  tbps_pkg::tri_t    corners,
  input  tbps_pkg::seeds_t  seeds,
  output logic              wq_push,
  output tbps_pkg::work_t   wq_data,
  input  logic              wq_full
);
  import tbps_pkg::*;

  logic ce;
  logic s1_v, s2_v, s3_v;

  vec_t [2:0]                          in_vtx;
  vec_t [2:0]                          s1_vtx, s2_vtx, s3_vtx;
  logic signed [2:0][HalfW-1:0]        sd_c, s1_sd;
  logic signed [2:0][2:0][HalfW-1:0]   vd_c, s1_vd;
  logic signed [2:0][2:0][ProdW-1:0]   s2_prod;
  logic signed [2:0][DistW-1:0]        s3_d;
  logic [2:0]                          pos, neg, edge_cut;
  logic [CoordW:0]                     adiff;
  logic [CoordW+1:0]                   vsum;

  // The pipeline moves whenever its last stage can drain into the queue.
  assign ce      = !s3_v || !wq_full;
  assign full    = !ce;
  assign wq_push = s3_v && !wq_full;

  assign in_vtx[0] = '{corners.corner0_x, corners.corner0_y, corners.corner0_z};
  assign in_vtx[1] = '{corners.corner1_x, corners.corner1_y, corners.corner1_z};
  assign in_vtx[2] = '{corners.corner2_x, corners.corner2_y, corners.corner2_z};

  // Stage 1 operands: asr(A-B, 2) and asr(2V-A-B, 3) for each axis.
  always_comb begin
    logic [2:0][CoordW-1:0] a, b;
    a = {seeds.a.x, seeds.a.y, seeds.a.z};
    b = {seeds.b.x, seeds.b.y, seeds.b.z};
    adiff = '0;
    vsum  = '0;
    sd_c  = '0;
    vd_c  = '0;
    for (int k = 0; k < 3; k++) begin
      adiff   = {a[k][CoordW-1], a[k]} - {b[k][CoordW-1], b[k]};
      sd_c[k] = adiff[CoordW:2];
      for (int i = 0; i < 3; i++) begin
        logic [2:0][CoordW-1:0] v;
        v = {in_vtx[i].x, in_vtx[i].y, in_vtx[i].z};
        vsum = {v[k][CoordW-1], v[k], 1'b0} - {{2{a[k][CoordW-1]}}, a[k]}
               - {{2{b[k][CoordW-1]}}, b[k]};
        vd_c[i][k] = vsum[CoordW+1:3];
      end
    end
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else if (ce) begin
      s1_v <= push;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  // Stage payloads: operands, products, distance sums.
  always_ff @(posedge clk) begin
    if (ce) begin
      s1_vtx <= in_vtx;
      s1_sd  <= sd_c;
      s1_vd  <= vd_c;
      s2_vtx <= s1_vtx;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          s2_prod[i][k] <= $signed(s1_sd[k]) * $signed(s1_vd[i][k]);
        end
      end
      s3_vtx <= s2_vtx;
      for (int i = 0; i < 3; i++) begin
        s3_d[i] <= {{2{s2_prod[i][0][ProdW-1]}}, s2_prod[i][0]}
                 + {{2{s2_prod[i][1][ProdW-1]}}, s2_prod[i][1]}
                 + {{2{s2_prod[i][2][ProdW-1]}}, s2_prod[i][2]};
      end
    end
  end

  // Sign tests and crossing edges.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg[i] = s3_d[i][DistW-1];
      pos[i] = !s3_d[i][DistW-1] && (s3_d[i] != '0);
    end
    edge_cut[0] = (pos[0] && neg[1]) || (neg[0] && pos[1]);
    edge_cut[1] = (pos[1] && neg[2]) || (neg[1] && pos[2]);
    edge_cut[2] = (pos[2] && neg[0]) || (neg[2] && pos[0]);
  end

  // Classification and distance magnitudes for the back end.
  always_comb begin
    wq_data.vtx = s3_vtx;
    for (int i = 0; i < 3; i++) begin
      wq_data.mag[i] = neg[i] ? MagW'(-s3_d[i]) : s3_d[i][MagW-1:0];
    end
    wq_data.cls = '0;
    unique case (edge_cut)
      3'b011: begin
        wq_data.cls.ncut = 2'd2; wq_data.cls.cut_edge0 = 2'd0;
        wq_data.cls.cut_edge1 = 2'd1; wq_data.cls.lone = 2'd1;
      end
      3'b110: begin
        wq_data.cls.ncut = 2'd2; wq_data.cls.cut_edge0 = 2'd1;
        wq_data.cls.cut_edge1 = 2'd2; wq_data.cls.lone = 2'd2;
      end
      3'b101, 3'b111: begin
        wq_data.cls.ncut = 2'd2; wq_data.cls.cut_edge0 = 2'd0;
        wq_data.cls.cut_edge1 = 2'd2; wq_data.cls.lone = 2'd0;
      end
      3'b001: begin wq_data.cls.ncut = 2'd1; wq_data.cls.cut_edge0 = 2'd0; end
      3'b010: begin wq_data.cls.ncut = 2'd1; wq_data.cls.cut_edge0 = 2'd1; end
      3'b100: begin wq_data.cls.ncut = 2'd1; wq_data.cls.cut_edge0 = 2'd2; end
      default: wq_data.cls.ncut = 2'd0;
    endcase
    wq_data.cls.lone_pos = pos[wq_data.cls.lone];
    wq_data.cls.e0_pos   = pos[wq_data.cls.cut_edge0];
    // Uncut triangle takes the side of its first corner off the plane.
    priority if (pos[0] || neg[0]) wq_data.cls.pass_b = neg[0];
    else if (pos[1] || neg[1])     wq_data.cls.pass_b = neg[1];
    else if (pos[2] || neg[2])     wq_data.cls.pass_b = neg[2];
    else                           wq_data.cls.pass_b = 1'b1;
  end

endmodule

// File: hw/rtl/tbps_workq.sv
module tbps_workq (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  tbps_pkg::work_t  wr_data,
  output logic             q_full,
  input  logic             rd,
  output tbps_pkg::work_t  rd_data,
  output logic             q_empty
);
  import tbps_pkg::*;

  work_t      slots [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign q_full  = (cnt == 2'd2);
  assign q_empty = (cnt == 2'd0);
  assign rd_data = slots[rp];

  // Two-entry queue between the front and the back.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) wp <= !wp;
      if (rd) rp <= !rp;
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slots[wp] <= wr_data;
  end

endmodule

// File: hw/rtl/tbps_back.sv
module tbps_back (
  input  logic             clk,
  input  logic             rst,
  output logic             wq_pop,
  input  tbps_pkg::work_t  wq_data,
  input  logic             wq_empty,
  output logic             empty,
  input  logic             pop,
  output tbps_pkg::piece_t piece
);
  import tbps_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_NORM = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0]               st;
  work_t                    w;
  logic                     ci;
  logic [MagW-1:0]          num;
  logic [DistW-1:0]         den;
  logic [HalfW-1:0]         rem;
  logic [TW-1:0]            t;
  logic [2:0]               stepc;
  logic signed [2:0][CoordW:0]   dv;
  vec_t                     vi;
  logic signed [2:0][DistW-1:0]  prodr;
  vec_t                     c0, c1;
  logic [1:0]               ri;

  work_t                    src;
  logic [1:0]               ce_i, ce_j;
  logic [2:0][CoordW-1:0]   vi_c, vj_c;
  logic [HalfW-1:0]         rem_n;
  logic [DivSteps-1:0]      qbits;
  logic                     q_top;
  vec_t                     cpt;
  pick_t                    pk;
  piece_t                   pc;
  logic                     oq_wr, oq_rd;
  piece_t                   oq [2];
  logic                     oq_wp, oq_rp;
  logic [1:0]               oq_cnt;

  // Cut edge setup: endpoints of the edge taken next.
  assign src  = (st == ST_IDLE) ? wq_data : w;
  assign ce_i = (st == ST_IDLE) ? src.cls.cut_edge0 : src.cls.cut_edge1;
  assign ce_j = next_corner(ce_i);
  assign vi_c = {src.vtx[ce_i].x, src.vtx[ce_i].y, src.vtx[ce_i].z};
  assign vj_c = {src.vtx[ce_j].x, src.vtx[ce_j].y, src.vtx[ce_j].z};

  assign wq_pop = (st == ST_IDLE) && !wq_empty;
  assign q_top  = num[HalfW-1:0] >= den[HalfW-1:0];

  // Five restoring division steps per cycle.
  always_comb begin
    logic [HalfW:0] rr;
    rem_n = rem;
    qbits = '0;
    for (int s = DivSteps - 1; s >= 0; s--) begin
      rr = {rem_n, 1'b0};
      qbits[s] = rr >= {1'b0, den[HalfW-1:0]};
      if (qbits[s]) rr = rr - {1'b0, den[HalfW-1:0]};
      rem_n = rr[HalfW-1:0];
    end
  end

  // Interpolated crossing point.
  always_comb begin
    logic [2:0][CoordW-1:0] base;
    logic [2:0][CoordW-1:0] res;
    logic signed [DistW-1:0] rs;
    base = {vi.x, vi.y, vi.z};
    for (int k = 0; k < 3; k++) begin
      rs = $signed(prodr[k]) + $signed(DistW'(1) << 29);
      rs = rs >>> 30;
      res[k] = base[k] + rs[CoordW-1:0];
    end
    cpt = '{res[2], res[1], res[0]};
  end

  // Sequencer: cut points one after another, then the pieces.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      unique case (st)
        ST_IDLE: if (!wq_empty) st <= (wq_data.cls.ncut == 2'd0) ? ST_EMIT : ST_NORM;
        ST_NORM: if (den[DistW-1:HalfW] == '0) st <= ST_DIV;
        ST_DIV:  if (stepc == 3'(DivCycles - 1)) st <= ST_MUL;
        ST_MUL:  st <= ST_ADD;
        ST_ADD:  st <= (!ci && w.cls.ncut == 2'd2) ? ST_NORM : ST_EMIT;
        ST_EMIT: if (oq_wr && pk.last) st <= ST_IDLE;
        default: st <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if ((st == ST_IDLE && !wq_empty) || (st == ST_ADD && !ci)) begin
      num <= src.mag[ce_i];
      den <= {1'b0, src.mag[ce_i]} + {1'b0, src.mag[ce_j]};
      vi  <= src.vtx[ce_i];
      for (int k = 0; k < 3; k++) begin
        dv[k] <= {vj_c[k][CoordW-1], vj_c[k]} - {vi_c[k][CoordW-1], vi_c[k]};
      end
    end
    if (st == ST_IDLE) begin
      w  <= wq_data;
      ci <= 1'b0;
      ri <= 2'd0;
    end
    if (st == ST_NORM) begin
      if (den[DistW-1:39] != '0) begin
        num <= num >> 8;
        den <= den >> 8;
      end else if (den[DistW-1:HalfW] != '0) begin
        num <= num >> 1;
        den <= den >> 1;
      end else begin
        t     <= {{(TW-1){1'b0}}, q_top};
        rem   <= q_top ? num[HalfW-1:0] - den[HalfW-1:0] : num[HalfW-1:0];
        stepc <= '0;
      end
    end
    if (st == ST_DIV) begin
      rem   <= rem_n;
      t     <= {t[TW-DivSteps-1:0], qbits};
      stepc <= stepc + 3'd1;
    end
    if (st == ST_MUL) begin
      for (int k = 0; k < 3; k++) begin
        prodr[k] <= DistW'($signed(dv[k]) * $signed({1'b0, t}));
      end
    end
    if (st == ST_ADD) begin
      if (ci) c1 <= cpt;
      else    c0 <= cpt;
      ci <= 1'b1;
    end
    if (oq_wr) ri <= ri + 2'd1;
  end

  // Piece assembly.
  function automatic vec_t pick_pt(input logic [2:0] s, input work_t wk,
                                   input vec_t p0, input vec_t p1);
    vec_t r;
    unique case (s)
      SEL_V0:  r = wk.vtx[0];
      SEL_V1:  r = wk.vtx[1];
      SEL_V2:  r = wk.vtx[2];
      SEL_C0:  r = p0;
      SEL_C1:  r = p1;
      default: r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    vec_t a, b, c;
    pk = pick_piece(w.cls, ri);
    a  = pick_pt(pk.s0, w, c0, c1);
    b  = pick_pt(pk.s1, w, c0, c1);
    c  = pick_pt(pk.s2, w, c0, c1);
    pc = '{pk.kind, a.x, a.y, a.z, b.x, b.y, b.z, c.x, c.y, c.z, pk.last};
  end

  // Two-entry result queue.
  assign oq_wr = (st == ST_EMIT) && (oq_cnt != 2'd2);
  assign oq_rd = pop && (oq_cnt != 2'd0);
  assign empty = (oq_cnt == 2'd0);
  assign piece = oq[oq_rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wp  <= 1'b0;
      oq_rp  <= 1'b0;
      oq_cnt <= 2'd0;
    end else begin
      if (oq_wr) oq_wp <= !oq_wp;
      if (oq_rd) oq_rp <= !oq_rp;
      oq_cnt <= oq_cnt + {1'b0, oq_wr} - {1'b0, oq_rd};
    end
  end

  always_ff @(posedge clk) begin
    if (oq_wr) oq[oq_wp] <= pc;
  end

endmodule

// File: verif/tb_triangle_bisector_plane_split.sv
module tb_triangle_bisector_plane_split;
  timeunit 1ns;
  timeprecision 1ps;

  import tbps_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int SettleCycles = 80;

  // Register indexes past the last seed register.
  localparam logic [2:0] RegSpareLo = 3'd6;
  localparam logic [2:0] RegSpareHi = 3'd7;

  // One row of the directed table; typed rows carry their single expected piece.
  typedef struct {
    tri_t   corner_set;
    bit     typed;
    piece_t want;
  } row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  tri_t                corners = '0;
  logic                empty;
  logic                pop = 1'b0;
  piece_t              piece;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrW-1:0]    paddr = '0;
  logic [DataW-1:0]    pwdata = '0;
  logic [DataW-1:0]    prdata;
  logic                pready;

  // Seed registers as the testbench believes them to be.
  logic signed [CoordW-1:0] seed_a [3];
  logic signed [CoordW-1:0] seed_b [3];

  piece_t pending_pieces[$];
  row_t   rows [$];
  int     error_count = 0;
  int     cycle_count = 0;
  int     pop_hold = 0;
  bit     calm = 1'b0;

  triangle_bisector_plane_split dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .corners(corners),
    .empty(empty), .pop(pop), .piece(piece),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Appends one expected piece to the scoreboard.
  function automatic void queue_piece(input piece_t p);
    pending_pieces = {pending_pieces, p};
  endfunction

  // Appends one row to the directed table.
  function automatic void add_row(input tri_t c, input bit typed, input piece_t want);
    row_t r;
    r.corner_set = c;
    r.typed = typed;
    r.want = want;
    rows = {rows, r};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Mostly coordinates near zero, sometimes full range or extremes.
  function automatic logic [31:0] rand_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 32'($urandom_range(0, 2097152)) - 32'd1048576;
    if (r < 85) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic tri_t rand_tri();
    return {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
            rand_coord(), rand_coord(), rand_coord(), rand_coord()};
  endfunction

  function automatic logic [63:0] magnitude(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic piece_t make_piece(input logic [1:0] kind, input vec_t p,
                                        input vec_t q, input vec_t r);
    return '{piece_kind: kind, out0_x: p.x, out0_y: p.y, out0_z: p.z,
             out1_x: q.x, out1_y: q.y, out1_z: q.z,
             out2_x: r.x, out2_y: r.y, out2_z: r.z, final_piece: 1'b0};
  endfunction

  // Splits one triangle by the bisector plane and queues the pieces it yields.
  function automatic void split_triangle(input tri_t t);
    longint     v [3][3];
    longint     d [3];
    longint     a;
    longint     b;
    longint     frac;
    logic [63:0] num;
    logic [63:0] den;
    vec_t       pt [5];
    int         cut_edge [2];
    int         ncut;
    int         j;
    int         lone;
    int         e;
    logic [1:0] lk;
    logic [1:0] qk;
    logic [1:0] kind;
    piece_t     out [$];
    v[0] = '{t.corner0_x, t.corner0_y, t.corner0_z};
    v[1] = '{t.corner1_x, t.corner1_y, t.corner1_z};
    v[2] = '{t.corner2_x, t.corner2_y, t.corner2_z};
    for (int i = 0; i < 3; i++) begin
      d[i] = 0;
      for (int k = 0; k < 3; k++) begin
        a = seed_a[k];
        b = seed_b[k];
        d[i] += ((a - b) >>> 2) * ((2 * v[i][k] - a - b) >>> 3);
      end
      pt[i] = {v[i][0][31:0], v[i][1][31:0], v[i][2][31:0]};
    end
    // Crossing points, in edge order.
    ncut = 0;
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      if ((d[i] > 0 && d[j] < 0) || (d[i] < 0 && d[j] > 0)) begin
        if (ncut < 2) begin
          num = magnitude(d[i]);
          den = num + magnitude(d[j]);
          while (den >= 64'h8000_0000) begin
            num = num >> 1;
            den = den >> 1;
          end
          frac = longint'((num << 30) / den);
          for (int k = 0; k < 3; k++) begin
            a = v[i][k] + (((v[j][k] - v[i][k]) * frac + (longint'(1) << 29)) >>> 30);
            pt[3 + ncut][95 - 32 * k -: 32] = a[31:0];
          end
          cut_edge[ncut] = i;
        end
        ncut++;
      end
    end
    if (ncut >= 2) begin
      lone = ((cut_edge[0] + cut_edge[1] + 1) * 2) % 3;
      lk = d[lone] > 0 ? KIND_A : KIND_B;
      qk = d[lone] > 0 ? KIND_B : KIND_A;
      case (lone)
        0: begin
          out = {out, make_piece(lk, pt[0], pt[3], pt[4])};
          out = {out, make_piece(qk, pt[1], pt[2], pt[3])};
          out = {out, make_piece(qk, pt[2], pt[4], pt[3])};
        end
        1: begin
          out = {out, make_piece(lk, pt[1], pt[4], pt[3])};
          out = {out, make_piece(qk, pt[0], pt[4], pt[2])};
          out = {out, make_piece(qk, pt[0], pt[3], pt[4])};
        end
        default: begin
          out = {out, make_piece(lk, pt[2], pt[4], pt[3])};
          out = {out, make_piece(qk, pt[0], pt[1], pt[4])};
          out = {out, make_piece(qk, pt[1], pt[3], pt[4])};
        end
      endcase
      out = {out, make_piece(KIND_SEG, pt[3], pt[4], '0)};
    end else if (ncut == 1) begin
      // The corner opposite the cut edge lies on the plane.
      e = cut_edge[0];
      if (d[e] > 0) begin
        out = {out, make_piece(KIND_A, pt[(e + 2) % 3], pt[e], pt[3])};
        out = {out, make_piece(KIND_B, pt[(e + 1) % 3], pt[(e + 2) % 3], pt[3])};
      end else begin
        out = {out, make_piece(KIND_A, pt[(e + 1) % 3], pt[(e + 2) % 3], pt[3])};
        out = {out, make_piece(KIND_B, pt[(e + 2) % 3], pt[e], pt[3])};
      end
      out = {out, make_piece(KIND_SEG, pt[3], pt[(e + 2) % 3], '0)};
    end else begin
      kind = KIND_B;
      for (int i = 2; i >= 0; i--) begin
        if (d[i] != 0) kind = d[i] > 0 ? KIND_A : KIND_B;
      end
      out = {out, make_piece(kind, pt[0], pt[1], pt[2])};
    end
    out[out.size() - 1].final_piece = 1'b1;
    foreach (out[i]) queue_piece(out[i]);
  endfunction

  // Sends one triangle; the prediction is made at the accepting edge.
  task automatic send_triangle(input tri_t t, input bit typed, input piece_t want);
    int gap;
    push <= 1'b1;
    corners <= t;
    do @(posedge clk); while (full);
    if (typed) queue_piece(want);
    else split_triangle(t);
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Register write: a setup phase, then an access phase.
  task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'(index) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (index == REG_SEED_A_X) seed_a[0] = value;
    else if (index == REG_SEED_A_Y) seed_a[1] = value;
    else if (index == REG_SEED_A_Z) seed_a[2] = value;
    else if (index == REG_SEED_B_X) seed_b[0] = value;
    else if (index == REG_SEED_B_Y) seed_b[1] = value;
    else if (index == REG_SEED_B_Z) seed_b[2] = value;
  endtask

  task automatic write_seeds(input logic [31:0] ax, input logic [31:0] ay,
                             input logic [31:0] az, input logic [31:0] bx,
                             input logic [31:0] by, input logic [31:0] bz);
    write_reg(REG_SEED_A_X, ax);
    write_reg(REG_SEED_A_Y, ay);
    write_reg(REG_SEED_A_Z, az);
    write_reg(REG_SEED_B_X, bx);
    write_reg(REG_SEED_B_Y, by);
    write_reg(REG_SEED_B_Z, bz);
  endtask

  // Holds the sender until every expected piece is out and the block is quiet.
  task automatic drain();
    push <= 1'b0;
    while (pending_pieces.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_triangle(rand_tri(), 1'b0, '0);
  endtask

  // Result side: check each popped piece, then choose the next pop.
  always @(posedge clk) begin
    piece_t want;
    int g;
    if (!rst && pop && !empty) begin
      if (pending_pieces.size() == 0) begin
        report("unexpected piece", 32'(piece.piece_kind), 32'hx);
      end else begin
        want = pending_pieces.pop_front();
        if (piece.piece_kind !== want.piece_kind)
          report("piece_kind", 32'(piece.piece_kind), 32'(want.piece_kind));
        if (piece.out0_x !== want.out0_x) report("out0_x", piece.out0_x, want.out0_x);
        if (piece.out0_y !== want.out0_y) report("out0_y", piece.out0_y, want.out0_y);
        if (piece.out0_z !== want.out0_z) report("out0_z", piece.out0_z, want.out0_z);
        if (piece.out1_x !== want.out1_x) report("out1_x", piece.out1_x, want.out1_x);
        if (piece.out1_y !== want.out1_y) report("out1_y", piece.out1_y, want.out1_y);
        if (piece.out1_z !== want.out1_z) report("out1_z", piece.out1_z, want.out1_z);
        if (piece.out2_x !== want.out2_x) report("out2_x", piece.out2_x, want.out2_x);
        if (piece.out2_y !== want.out2_y) report("out2_y", piece.out2_y, want.out2_y);
        if (piece.out2_z !== want.out2_z) report("out2_z", piece.out2_z, want.out2_z);
        if (piece.final_piece !== want.final_piece)
          report("final_piece", 32'(piece.final_piece), 32'(want.final_piece));
      end
    end
    if (pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
      pop <= 1'b0;
    end else begin
      g = pick_gap();
      pop <= (g == 0);
      pop_hold <= (g > 0) ? g - 1 : 0;
    end
  end

  initial begin
    tri_t t;
    logic [31:0] s;
    seed_a = '{0, 0, 0};
    seed_b = '{SEED_B_X_RESET, 0, 0};

    // With the reset seeds the plane is x = 0.5.
    t = {32'h0, 32'h1, 32'h2, 32'h0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h30000};
    add_row(t, 1'b1, {KIND_A, t[287:0], 1'b1});
    t = {32'h10000, 32'h5, 32'h0, 32'h10000, 32'h0, 32'h7, 32'h20000, 32'h0, 32'h0};
    add_row(t, 1'b1, {KIND_B, t[287:0], 1'b1});
    // Every corner on the plane passes with the B kind.
    t = {32'h8000, 32'h0, 32'h0, 32'h8000, 32'h10000, 32'h0, 32'h8000, 32'h0, 32'h10000};
    add_row(t, 1'b1, {KIND_B, t[287:0], 1'b1});
    // Two crossings, each corner taking the lone role in turn.
    add_row({32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0,
             32'h10000, 32'h10000, 32'h0}, 1'b0, '0);
    add_row({32'h10000, 32'h0, 32'h0, 32'h0, 32'h3000, 32'h0,
             32'h30000, 32'h10000, 32'h4}, 1'b0, '0);
    add_row({32'h10000, 32'h0, 32'h0, 32'h20000, 32'h1, 32'h0,
             32'hffff0000, 32'h10000, 32'h0}, 1'b0, '0);
    add_row({32'hfffe0000, 32'h0, 32'h0, 32'hffff8000, 32'h2000, 32'h0,
             32'h50000, 32'h10000, 32'h20}, 1'b0, '0);
    // One crossing with a corner on the plane, on each edge, edge 0 in both orders.
    add_row({32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0,
             32'h8000, 32'h10000, 32'h0}, 1'b0, '0);
    add_row({32'h10000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
             32'h8000, 32'h10000, 32'h0}, 1'b0, '0);
    add_row({32'h8000, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0,
             32'h30000, 32'h0, 32'h10000}, 1'b0, '0);
    add_row({32'hffff0000, 32'h0, 32'h0, 32'h8000, 32'h10000, 32'h0,
             32'h10000, 32'h0, 32'h10000}, 1'b0, '0);
    // Extreme coordinates.
    add_row({32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
             32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
             32'hffffffff}, 1'b0, '0);
    add_row({32'h7fffffff, 32'h0, 32'h80000000, 32'h80000000,
             32'hffffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
             32'h0}, 1'b0, '0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_triangle(rows[i].corner_set, rows[i].typed, rows[i].want);
    drain();

    // Writes beyond the last register must be ignored.
    write_reg(RegSpareLo, $urandom);
    write_reg(RegSpareHi, $urandom);
    send_random(10);
    drain();

    // Nearby random seeds, first stretch without idling.
    write_seeds(rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), rand_coord(), rand_coord());
    calm = 1'b1;
    send_random(20);
    calm = 1'b0;
    send_random(25);
    drain();

    // Seeds at the extremes of the range.
    write_seeds(32'h80000000, 32'h7fffffff, 32'h80000000,
                32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_random(25);
    drain();

    // Equal seeds leave no plane; every triangle passes with the B kind.
    s = rand_coord();
    write_seeds(s, 32'h1234, 32'hffff0000, s, 32'h1234, 32'hffff0000);
    send_random(10);
    drain();

    write_seeds(rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), rand_coord(), rand_coord());
    send_random(70);
    drain();

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
